@@ rtl/xrst_pkg.sv @@
// ----------------------------------------------------------------------------
// XOR remapped range sum tree package
// Shared field widths, defaults and command codes.
// ----------------------------------------------------------------------------
package xrst_pkg;

	localparam int ADDR_BITS_DEF = 18;
	localparam int IDX_W         = 18;
	localparam int VAL_W         = 32;
	localparam int K_W           = 5;
	localparam int SUM_W         = 50;
	localparam int CMD_W         = 2;

	typedef logic [CMD_W-1:0] cmd_t;

	localparam cmd_t CMD_SET   = 2'd0;
	localparam cmd_t CMD_REV   = 2'd1;
	localparam cmd_t CMD_SWAP  = 2'd2;
	localparam cmd_t CMD_QUERY = 2'd3;

endpackage

@@ rtl/xor_remapped_range_sum_tree.sv @@
// ----------------------------------------------------------------------------
// XOR remapped range sum tree
// Segment tree of subtree sums over 2^ADDR_BITS values with an XOR index mask.
// ----------------------------------------------------------------------------
// After reset the block clears all 2^(ADDR_BITS+1) entries of its node
// memory, one entry per cycle, with busy high. Reverse and swap requests take
// effect at acceptance and leave busy low. A set request holds busy for one
// leaf read, then one read-modify-write per tree level up to the root. A
// query request holds busy for one node read per level for each prefix walk,
// with a second walk only when left is nonzero; range_sum and done appear in
// the same cycle that busy falls. An empty range (left above right) gives done
// with zero in the cycle after acceptance. The node memory has a single read
// port. Each result is shown for one cycle only and the receiver cannot
// hold it off.
module xor_remapped_range_sum_tree #(
	parameter int ADDR_BITS = xrst_pkg::ADDR_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  xrst_pkg::cmd_t                 cmd,
	input  logic [xrst_pkg::IDX_W-1:0]     index,
	input  logic [xrst_pkg::VAL_W-1:0]     value,
	input  logic [xrst_pkg::K_W-1:0]       bit_count,
	input  logic [xrst_pkg::IDX_W-1:0]     left,
	input  logic [xrst_pkg::IDX_W-1:0]     right,
	output logic                           done,
	output logic [xrst_pkg::SUM_W-1:0]     range_sum
);

	localparam int NODE_W = ADDR_BITS + 1;
	localparam int CNT_W  = $clog2(ADDR_BITS + 1);
	localparam int EXT_W  = xrst_pkg::IDX_W + ADDR_BITS;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_LEAF = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_WALK = 3'd4;
	localparam logic [2:0] ST_WAIT = 3'd5;

	logic [2:0]                     state_q;
	logic [NODE_W-1:0]              clr_q;
	logic [NODE_W-1:0]              node_q;
	logic [ADDR_BITS-1:0]           mask_q;
	logic [ADDR_BITS-1:0]           key_q;
	logic [ADDR_BITS-1:0]           mk_q;
	logic [ADDR_BITS-1:0]           lo_q;
	logic [CNT_W-1:0]               cnt_q;
	logic                           pass_q;
	logic                           first_q;
	logic [xrst_pkg::VAL_W-1:0]     value_q;
	logic [xrst_pkg::SUM_W-1:0]     diff_q;
	logic [xrst_pkg::SUM_W-1:0]     acc_q;
	logic [xrst_pkg::SUM_W-1:0]     range_sum_q;
	logic                           done_q;
	logic                           add_s1;
	logic                           sub_s1;

	logic [EXT_W-1:0]               index_ext;
	logic [EXT_W-1:0]               left_ext;
	logic [EXT_W-1:0]               right_ext;
	logic [ADDR_BITS-1:0]           idx_c;
	logic [ADDR_BITS-1:0]           lo_c;
	logic [ADDR_BITS-1:0]           hi_c;
	logic [ADDR_BITS-1:0]           rev_bits;
	logic [ADDR_BITS-1:0]           swap_bits;
	logic                           accept;
	logic                           rd_add_c;
	logic                           we;
	logic [NODE_W-1:0]              waddr;
	logic [xrst_pkg::SUM_W-1:0]     wdata;
	logic [NODE_W-1:0]              raddr;
	logic [xrst_pkg::SUM_W-1:0]     rdata;
	logic [xrst_pkg::SUM_W-1:0]     acc_nxt;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign index_ext = {{ADDR_BITS{1'b0}}, index};
	assign left_ext  = {{ADDR_BITS{1'b0}}, left};
	assign right_ext = {{ADDR_BITS{1'b0}}, right};
	assign idx_c     = index_ext[ADDR_BITS-1:0];
	assign lo_c      = left_ext[ADDR_BITS-1:0];
	assign hi_c      = right_ext[ADDR_BITS-1:0];

	always_comb begin
		for (int b = 0; b < ADDR_BITS; b++) begin
			rev_bits[b]  = (int'(bit_count) > b);
			swap_bits[b] = (int'(bit_count) == b);
		end
	end

	always_comb begin
		we       = 1'b0;
		waddr    = clr_q;
		wdata    = '0;
		raddr    = node_q;
		rd_add_c = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				we = 1'b1;
			end
			ST_UPD: begin
				we    = 1'b1;
				waddr = node_q;
				wdata = first_q ? xrst_pkg::SUM_W'(value_q) : rdata + diff_q;
				raddr = node_q >> 1;
			end
			ST_WALK: begin
				if (cnt_q != '0) begin
					raddr    = NODE_W'({node_q, mk_q[ADDR_BITS-1]});
					rd_add_c = key_q[ADDR_BITS-1];
				end else begin
					rd_add_c = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		acc_nxt = acc_q;
		if (add_s1) begin
			acc_nxt = sub_s1 ? acc_q - rdata : acc_q + rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			node_q      <= '0;
			mask_q      <= '0;
			key_q       <= '0;
			mk_q        <= '0;
			lo_q        <= '0;
			cnt_q       <= '0;
			pass_q      <= 1'b0;
			first_q     <= 1'b0;
			value_q     <= '0;
			diff_q      <= '0;
			acc_q       <= '0;
			range_sum_q <= '0;
			done_q      <= 1'b0;
			add_s1      <= 1'b0;
			sub_s1      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			add_s1 <= (state_q == ST_WALK) && rd_add_c;
			sub_s1 <= pass_q;
			acc_q  <= acc_nxt;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd)
							xrst_pkg::CMD_SET: begin
								node_q  <= {1'b1, idx_c ^ mask_q};
								value_q <= value;
								state_q <= ST_LEAF;
							end
							xrst_pkg::CMD_REV: begin
								mask_q <= mask_q ^ rev_bits;
							end
							xrst_pkg::CMD_SWAP: begin
								mask_q <= mask_q ^ swap_bits;
							end
							xrst_pkg::CMD_QUERY: begin
								if (lo_c > hi_c) begin
									range_sum_q <= '0;
									done_q      <= 1'b1;
								end else begin
									key_q   <= hi_c;
									mk_q    <= mask_q;
									lo_q    <= lo_c;
									node_q  <= NODE_W'(1);
									cnt_q   <= CNT_W'(ADDR_BITS);
									pass_q  <= 1'b0;
									acc_q   <= '0;
									state_q <= ST_WALK;
								end
							end
						endcase
					end
				end
				ST_LEAF: begin
					first_q <= 1'b1;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					first_q <= 1'b0;
					if (first_q) begin
						diff_q <= xrst_pkg::SUM_W'(value_q) - rdata;
					end
					node_q <= node_q >> 1;
					if (node_q == NODE_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					if (cnt_q != '0) begin
						node_q <= NODE_W'({node_q, mk_q[ADDR_BITS-1] ^ key_q[ADDR_BITS-1]});
						key_q  <= key_q << 1;
						mk_q   <= mk_q << 1;
						cnt_q  <= cnt_q - 1'b1;
					end else if (!pass_q && (lo_q != '0)) begin
						key_q  <= lo_q - 1'b1;
						mk_q   <= mask_q;
						node_q <= NODE_W'(1);
						cnt_q  <= CNT_W'(ADDR_BITS);
						pass_q <= 1'b1;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					range_sum_q <= acc_nxt;
					done_q      <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	xrst_node_ram #(
		.AW (NODE_W),
		.DW (xrst_pkg::SUM_W)
	) u_node_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign done      = done_q;
	assign range_sum = range_sum_q;

endmodule

@@ rtl/xrst_node_ram.sv @@
// ----------------------------------------------------------------------------
// Node sum memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module xrst_node_ram #(
	parameter int AW = xrst_pkg::ADDR_BITS_DEF + 1,
	parameter int DW = xrst_pkg::SUM_W
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [0:(2**AW)-1];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/xrst_check.sv @@
// ----------------------------------------------------------------------------
// XOR remapped range sum tree checker
// Port level checks on request acceptance and the result strobe.
// ----------------------------------------------------------------------------
module xrst_check (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input xrst_pkg::cmd_t cmd,
	input logic           done
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("Result strobe raised while busy.");

	a_set_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd == xrst_pkg::CMD_SET)) |=> busy)
		else $error("Set request did not raise busy.");

	a_mask_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && ((cmd == xrst_pkg::CMD_REV) || (cmd == xrst_pkg::CMD_SWAP)))
		|=> (!busy && !done))
		else $error("Mask request raised busy or a result.");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start && (cmd == xrst_pkg::CMD_QUERY))))
		else $error("Result strobe without a query request.");

endmodule

bind xor_remapped_range_sum_tree xrst_check u_xrst_check (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done)
);

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// XOR remapped range sum tree testbench
// Issues set, reverse, swap and query requests through the start/busy
// handshake. A scoreboard keeps its own segment tree and index mask, works out
// each range sum on acceptance and compares it with every done strobe in order.
// ----------------------------------------------------------------------------
module tb;

	localparam int AB         = xrst_pkg::ADDR_BITS_DEF;
	localparam int RAND_ITEMS = 525;

	class range_sum_tracker;
		localparam int NB = xrst_pkg::ADDR_BITS_DEF;

		bit [xrst_pkg::VAL_W-1:0] slot_vals [0:2**NB-1];
		bit [xrst_pkg::SUM_W-1:0] tree_sums [0:2**(NB+1)-1];
		bit [NB-1:0]              slot_mask;
		bit [xrst_pkg::SUM_W-1:0] sums_due [$];
		int                       faults;

		function bit [xrst_pkg::SUM_W-1:0] prefix_total(bit [NB-1:0] last);
			bit [xrst_pkg::SUM_W-1:0] acc;
			int unsigned              node;
			acc = '0;
			node = 1;
			for (int lvl = NB - 1; lvl >= 0; lvl--) begin
				if (last[lvl]) begin
					acc += tree_sums[2 * node + slot_mask[lvl]];
					node = 2 * node + !slot_mask[lvl];
				end else begin
					node = 2 * node + slot_mask[lvl];
				end
			end
			return acc + tree_sums[node];
		endfunction

		function void note_request(xrst_pkg::cmd_t c, bit [xrst_pkg::IDX_W-1:0] idx,
				bit [xrst_pkg::VAL_W-1:0] val, bit [xrst_pkg::K_W-1:0] k,
				bit [xrst_pkg::IDX_W-1:0] lo_in, bit [xrst_pkg::IDX_W-1:0] hi_in);
			bit [NB-1:0]              slot;
			bit [NB-1:0]              lo;
			bit [NB-1:0]              hi;
			bit [xrst_pkg::SUM_W-1:0] delta;
			bit [xrst_pkg::SUM_W-1:0] total;
			int unsigned              node;
			case (c)
				xrst_pkg::CMD_SET: begin
					slot = NB'(idx) ^ slot_mask;
					delta = xrst_pkg::SUM_W'(val) - xrst_pkg::SUM_W'(slot_vals[slot]);
					slot_vals[slot] = val;
					node = (1 << NB) + slot;
					while (node != 0) begin
						tree_sums[node] += delta;
						node >>= 1;
					end
				end
				xrst_pkg::CMD_REV: begin
					if (k >= NB)
						slot_mask = ~slot_mask;
					else
						slot_mask ^= NB'((1 << k) - 1);
				end
				xrst_pkg::CMD_SWAP: begin
					if (k < NB)
						slot_mask ^= NB'(1 << k);
				end
				xrst_pkg::CMD_QUERY: begin
					lo = NB'(lo_in);
					hi = NB'(hi_in);
					total = '0;
					if (lo <= hi) begin
						total = prefix_total(hi);
						if (lo != 0)
							total -= prefix_total(lo - 1'b1);
					end
					sums_due.push_back(total);
				end
			endcase
		endfunction

		function void check_sum(bit [xrst_pkg::SUM_W-1:0] actual);
			bit [xrst_pkg::SUM_W-1:0] want;
			if (sums_due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("range_sum %0d arrived with no query outstanding", actual);
			end else begin
				want = sums_due.pop_front();
				if (want !== actual) begin
					faults++;
					if (faults <= 10)
						$display("range_sum differs: expected %0d, got %0d", want, actual);
				end
			end
		endfunction

		function int pending();
			return sums_due.size();
		endfunction
	endclass

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           start     = 1'b0;
	xrst_pkg::cmd_t                 cmd       = xrst_pkg::CMD_SET;
	logic [xrst_pkg::IDX_W-1:0]     index     = '0;
	logic [xrst_pkg::VAL_W-1:0]     value     = '0;
	logic [xrst_pkg::K_W-1:0]       bit_count = '0;
	logic [xrst_pkg::IDX_W-1:0]     left      = '0;
	logic [xrst_pkg::IDX_W-1:0]     right     = '0;
	logic                           busy;
	logic                           done;
	logic [xrst_pkg::SUM_W-1:0]     range_sum;

	range_sum_tracker sb = new();
	int               idle_pct;

	xor_remapped_range_sum_tree #(
		.ADDR_BITS(AB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.index(index),
		.value(value),
		.bit_count(bit_count),
		.left(left),
		.right(right),
		.done(done),
		.range_sum(range_sum)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_sum(range_sum);
	end

	task automatic issue(xrst_pkg::cmd_t c, bit [xrst_pkg::IDX_W-1:0] idx,
			bit [xrst_pkg::VAL_W-1:0] val, bit [xrst_pkg::K_W-1:0] k,
			bit [xrst_pkg::IDX_W-1:0] lo, bit [xrst_pkg::IDX_W-1:0] hi);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		index <= idx;
		value <= val;
		bit_count <= k;
		left <= lo;
		right <= hi;
		do @(posedge clk); while (busy);
		sb.note_request(c, idx, val, k, lo, hi);
	endtask

	task automatic random_request();
		xrst_pkg::cmd_t                 c;
		bit [xrst_pkg::IDX_W-1:0]       idx;
		bit [xrst_pkg::IDX_W-1:0]       lo;
		bit [xrst_pkg::IDX_W-1:0]       hi;
		bit [xrst_pkg::IDX_W-1:0]       t;
		bit [xrst_pkg::VAL_W-1:0]       val;
		bit [xrst_pkg::K_W-1:0]         k;
		int                             pick;
		idx = xrst_pkg::IDX_W'($urandom);
		val = xrst_pkg::VAL_W'($urandom);
		lo = xrst_pkg::IDX_W'($urandom);
		hi = xrst_pkg::IDX_W'($urandom);
		if ($urandom_range(0, 3) == 0)
			k = xrst_pkg::K_W'($urandom_range(0, 31));
		else
			k = xrst_pkg::K_W'($urandom_range(0, AB - 1));
		pick = $urandom_range(0, 99);
		if (pick < 40)
			c = xrst_pkg::CMD_SET;
		else if (pick < 50)
			c = xrst_pkg::CMD_REV;
		else if (pick < 60)
			c = xrst_pkg::CMD_SWAP;
		else
			c = xrst_pkg::CMD_QUERY;
		if (c == xrst_pkg::CMD_SET) begin
			if ($urandom_range(0, 1))
				idx = xrst_pkg::IDX_W'($urandom_range(0, 255));
			pick = $urandom_range(0, 9);
			if (pick == 0)
				val = '0;
			else if (pick == 1)
				val = '1;
		end else if (c == xrst_pkg::CMD_QUERY) begin
			pick = $urandom_range(0, 9);
			if (pick >= 1 && pick <= 3) begin
				lo = xrst_pkg::IDX_W'($urandom_range(0, 255));
				hi = lo + xrst_pkg::IDX_W'($urandom_range(0, 255));
			end else if (pick >= 4) begin
				if (lo > hi) begin
					t = lo;
					lo = hi;
					hi = t;
				end
				if (pick == 9)
					lo = '0;
			end
		end
		issue(c, idx, val, k, lo, hi);
	endtask

	initial begin
		#40_000_000;
		$display("xor_remapped_range_sum_tree: mismatch");
		$finish;
	end

	initial begin
		idle_pct = 7;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		issue(xrst_pkg::CMD_QUERY, '0, '0, '0, '0, '1);
		issue(xrst_pkg::CMD_SET, '0, '1, '0, '0, '0);
		issue(xrst_pkg::CMD_SET, '1, '1, '0, '0, '0);
		issue(xrst_pkg::CMD_SET, 18'h15555, 32'h1234_5678, '0, '0, '0);
		issue(xrst_pkg::CMD_SET, 18'h2aaaa, 32'ha5a5_a5a5, '0, '0, '0);
		issue(xrst_pkg::CMD_QUERY, '0, '0, '0, '0, '1);
		issue(xrst_pkg::CMD_QUERY, '0, '0, '0, '1, '0);
		issue(xrst_pkg::CMD_QUERY, '0, '0, '0, '0, '0);
		issue(xrst_pkg::CMD_QUERY, '0, '0, '0, '1, '1);
		issue(xrst_pkg::CMD_REV, '0, '0, 5'd0, '0, '0);
		issue(xrst_pkg::CMD_REV, '0, '0, 5'd5, '0, '0);
		issue(xrst_pkg::CMD_QUERY, '0, '0, '0, 18'd1, '1);
		issue(xrst_pkg::CMD_SWAP, '0, '0, 5'd17, '0, '0);
		issue(xrst_pkg::CMD_QUERY, '0, '0, '0, '0, 18'h1ffff);
		issue(xrst_pkg::CMD_REV, '0, '0, 5'd18, '0, '0);
		issue(xrst_pkg::CMD_REV, '0, '0, 5'd31, '0, '0);
		issue(xrst_pkg::CMD_SWAP, '0, '0, 5'd18, '0, '0);
		issue(xrst_pkg::CMD_SWAP, '0, '0, 5'd31, '0, '0);
		issue(xrst_pkg::CMD_SWAP, '0, '0, 5'd0, '0, '0);
		issue(xrst_pkg::CMD_SET, '0, '0, '0, '0, '0);
		issue(xrst_pkg::CMD_SET, 18'h2aaaa, 32'd1, '0, '0, '0);
		issue(xrst_pkg::CMD_QUERY, '0, '0, '0, 18'h15555, 18'h2aaaa);
		issue(xrst_pkg::CMD_QUERY, '0, '0, '0, 18'd1, 18'h3fffe);
		issue(xrst_pkg::CMD_REV, '0, '0, 5'd17, '0, '0);
		issue(xrst_pkg::CMD_QUERY, '0, '0, '0, '0, '1);

		repeat (RAND_ITEMS) random_request();

		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);

		idle_pct = 84;
		repeat (RAND_ITEMS) random_request();
		idle_pct = 0;
		repeat (RAND_ITEMS) random_request();
		start <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (2 * AB + 8) @(posedge clk);
		if (sb.faults == 0)
			$display("xor_remapped_range_sum_tree: match");
		else
			$display("xor_remapped_range_sum_tree: mismatch");
		$finish;
	end

endmodule
